// File: rtl/mlas_pkg.sv
// ----------------------------------------------------------------------------
// mlas_pkg
// Shared types, sizes and codes for the multi-list append/splice manager.
// ----------------------------------------------------------------------------
package mlas_pkg;

  // Sizes of the list tables and the node pool
  localparam int NUM_LISTS   = 16;
  localparam int POOL_NODES  = 64;
  localparam int VALUE_WIDTH = 32;

  // Fixed port widths
  localparam int REQ_W = 2;
  localparam int IDX_W = 4;
  localparam int OUT_W = 32;
  localparam int CFG_W = 5;

  localparam int LISTS_RESET = 16;

  // Derived widths
  localparam int LIST_W = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int NODE_W = $clog2(POOL_NODES);
  localparam int CNT_W  = NODE_W + 1;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT  = 2'd0,
    REQ_DUMP    = 2'd1,
    REQ_SPLICE  = 2'd2,
    REQ_IGNORED = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_POOL_FULL = 2'd1,
    STAT_BAD_INDEX = 2'd2
  } status_e;

  // Controller to datapath
  typedef struct packed {
    logic    load;           // latch request, read pointer tables
    logic    commit_insert;  // allocate node and link it in
    logic    commit_splice;  // move source list onto target
    logic    walk_load;      // start dump walk at head of target
    logic    walk_next;      // advance walk to next node
    logic    emit;           // load output register
    logic    emit_elem;      // output value comes from current node
    logic    emit_last;
    logic    emit_empty;
    status_e emit_status;
  } mlas_cmd_t;

  // Datapath to controller
  typedef struct packed {
    req_e req;
    logic bad_index;
    logic pool_full;
    logic tgt_nonempty;
    logic src_nonempty;
    logic same_list;
    logic walk_last;
    logic out_free;
  } mlas_stat_t;

endpackage

// File: rtl/mlas_ctrl.sv
// ----------------------------------------------------------------------------
// mlas_ctrl
// Request sequencer: accepts one request, executes it and walks dump chains.
// ----------------------------------------------------------------------------
module mlas_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mlas_pkg::mlas_stat_t stat_i,
  output mlas_pkg::mlas_cmd_t  cmd_o
);
  import mlas_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  // Next state and command decode
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.emit_status = STAT_OK;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat_i.req == REQ_IGNORED) begin
          state_d = ST_IDLE;
        end else if (stat_i.bad_index) begin
          if (stat_i.out_free) begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_last   = 1'b1;
            cmd_o.emit_status = STAT_BAD_INDEX;
            state_d           = ST_IDLE;
          end
        end else begin
          case (stat_i.req)
            REQ_INSERT: begin
              if (stat_i.out_free) begin
                cmd_o.emit          = 1'b1;
                cmd_o.emit_last     = 1'b1;
                cmd_o.emit_status   = stat_i.pool_full ? STAT_POOL_FULL : STAT_OK;
                cmd_o.commit_insert = !stat_i.pool_full;
                state_d             = ST_IDLE;
              end
            end
            REQ_SPLICE: begin
              if (stat_i.out_free) begin
                cmd_o.emit          = 1'b1;
                cmd_o.emit_last     = 1'b1;
                cmd_o.commit_splice = !stat_i.same_list && stat_i.src_nonempty;
                state_d             = ST_IDLE;
              end
            end
            REQ_DUMP: begin
              if (!stat_i.tgt_nonempty) begin
                if (stat_i.out_free) begin
                  cmd_o.emit       = 1'b1;
                  cmd_o.emit_last  = 1'b1;
                  cmd_o.emit_empty = 1'b1;
                  state_d          = ST_IDLE;
                end
              end else begin
                cmd_o.walk_load = 1'b1;
                state_d         = ST_WALK;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_WALK: begin
        if (stat_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_elem = 1'b1;
          cmd_o.emit_last = stat_i.walk_last;
          if (stat_i.walk_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.walk_next = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A walk only runs for a nonempty dump
  a_walk_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && state_d == ST_WALK) |->
      (stat_i.req == REQ_DUMP && stat_i.tgt_nonempty && !stat_i.bad_index))
    else $error("walk started without a nonempty dump");

  // Leaving the walk always delivers the tail element
  a_walk_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK && state_d == ST_IDLE) |-> (cmd_o.emit && cmd_o.emit_last))
    else $error("walk ended without a last transfer");

  // A loaded request always enters execution
  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ST_EXEC))
    else $error("request load did not enter execution");

endmodule

// File: rtl/mlas_dp.sv
// ----------------------------------------------------------------------------
// mlas_dp
// Datapath: request register, pointer tables, node memories, bump allocator,
// dump walk pointer and output register.
// ----------------------------------------------------------------------------
module mlas_dp (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_valid_i,
  input  logic [mlas_pkg::CFG_W-1:0]              cfg_lists_in_use_i,
  input  logic [mlas_pkg::REQ_W-1:0]              req_type_i,
  input  logic [mlas_pkg::IDX_W-1:0]              target_list_i,
  input  logic [mlas_pkg::IDX_W-1:0]              source_list_i,
  input  logic signed [31:0]                      value_i,
  input  mlas_pkg::mlas_cmd_t                     cmd_i,
  output mlas_pkg::mlas_stat_t                    stat_o,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [mlas_pkg::OUT_W-1:0]       out_value_o,
  output logic                                    is_last_o,
  output logic                                    is_empty_o,
  output logic [1:0]                              status_o
);
  import mlas_pkg::*;

  // Configuration
  logic [CFG_W-1:0] lists_q;

  // Latched request
  req_e                          req_q;
  logic [IDX_W-1:0]              tgt_q, src_q;
  logic signed [VALUE_WIDTH-1:0] val_q;

  // Pointer tables (no reset) and nonempty flags (reset)
  logic [NODE_W-1:0] head_mem [NUM_LISTS];
  logic [NODE_W-1:0] tail_mem [NUM_LISTS];
  logic [NUM_LISTS-1:0] nonempty_q;
  logic [NODE_W-1:0] head_t_q, head_s_q, tail_t_q, tail_s_q;
  logic [LIST_W-1:0] rd_t, rd_s, tgt_ix, src_ix;

  // Node pool
  logic [NODE_W-1:0]             next_mem [POOL_NODES];
  logic signed [VALUE_WIDTH-1:0] val_mem  [POOL_NODES];
  logic [NODE_W-1:0]             next_rd_q, node_addr;
  logic signed [VALUE_WIDTH-1:0] val_rd_q;
  logic [CNT_W-1:0]              alloc_q;

  // Walk state
  logic [NODE_W-1:0] p_q;
  logic [NODE_W-1:0] k_q;

  // Output register
  logic                    out_valid_q, out_last_q, out_empty_q;
  logic signed [OUT_W-1:0] out_value_q;
  status_e                 out_status_q;

  logic out_free;

  function automatic logic idx_ok(input logic [IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] lim);
    logic in_pool;
    in_pool = (int'(idx) < NUM_LISTS);
    return in_pool && ((IDX_W+CFG_W)'(idx) < (IDX_W+CFG_W)'(lim));
  endfunction

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lists_q <= CFG_W'(LISTS_RESET);
    end else if (cfg_valid_i) begin
      lists_q <= cfg_lists_in_use_i;
    end
  end

  // Request register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_e'(req_type_i);
      tgt_q <= target_list_i;
      src_q <= source_list_i;
      val_q <= VALUE_WIDTH'(value_i);
    end
  end

  assign tgt_ix = tgt_q[LIST_W-1:0];
  assign src_ix = src_q[LIST_W-1:0];
  assign rd_t   = cmd_i.load ? target_list_i[LIST_W-1:0] : tgt_ix;
  assign rd_s   = cmd_i.load ? source_list_i[LIST_W-1:0] : src_ix;

  // Head pointer table
  always_ff @(posedge clk_i) begin
    head_t_q <= head_mem[rd_t];
    head_s_q <= head_mem[rd_s];
    if (cmd_i.commit_insert && !nonempty_q[tgt_ix]) begin
      head_mem[tgt_ix] <= alloc_q[NODE_W-1:0];
    end else if (cmd_i.commit_splice && !nonempty_q[tgt_ix]) begin
      head_mem[tgt_ix] <= head_s_q;
    end
  end

  // Tail pointer table
  always_ff @(posedge clk_i) begin
    tail_t_q <= tail_mem[rd_t];
    tail_s_q <= tail_mem[rd_s];
    if (cmd_i.commit_insert) begin
      tail_mem[tgt_ix] <= alloc_q[NODE_W-1:0];
    end else if (cmd_i.commit_splice) begin
      tail_mem[tgt_ix] <= tail_s_q;
    end
  end

  // Nonempty flags and allocator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nonempty_q <= '0;
      alloc_q    <= '0;
    end else begin
      if (cmd_i.commit_insert) begin
        nonempty_q[tgt_ix] <= 1'b1;
        alloc_q            <= alloc_q + CNT_W'(1);
      end else if (cmd_i.commit_splice) begin
        nonempty_q[src_ix] <= 1'b0;
        nonempty_q[tgt_ix] <= 1'b1;
      end
    end
  end

  // Node memory read address follows the walk
  always_comb begin
    if (cmd_i.walk_load) begin
      node_addr = head_t_q;
    end else if (cmd_i.walk_next) begin
      node_addr = next_rd_q;
    end else begin
      node_addr = p_q;
    end
  end

  // Next-link memory
  always_ff @(posedge clk_i) begin
    next_rd_q <= next_mem[node_addr];
    if (cmd_i.commit_insert && nonempty_q[tgt_ix]) begin
      next_mem[tail_t_q] <= alloc_q[NODE_W-1:0];
    end else if (cmd_i.commit_splice && nonempty_q[tgt_ix]) begin
      next_mem[tail_t_q] <= head_s_q;
    end
  end

  // Value memory
  always_ff @(posedge clk_i) begin
    val_rd_q <= val_mem[node_addr];
    if (cmd_i.commit_insert) begin
      val_mem[alloc_q[NODE_W-1:0]] <= val_q;
    end
  end

  // Walk pointer and element count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= '0;
      k_q <= '0;
    end else if (cmd_i.walk_load) begin
      p_q <= head_t_q;
      k_q <= '0;
    end else if (cmd_i.walk_next) begin
      p_q <= next_rd_q;
      k_q <= k_q + NODE_W'(1);
    end
  end

  // Output register
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_value_q  <= cmd_i.emit_elem ? OUT_W'(val_rd_q) : '0;
      out_last_q   <= cmd_i.emit_last;
      out_empty_q  <= cmd_i.emit_empty;
      out_status_q <= cmd_i.emit_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign is_last_o   = out_last_q;
  assign is_empty_o  = out_empty_q;
  assign status_o    = out_status_q;

  // Status to controller
  always_comb begin
    stat_o.req          = req_q;
    stat_o.bad_index    = !idx_ok(tgt_q, lists_q) ||
                          (req_q == REQ_SPLICE && !idx_ok(src_q, lists_q));
    stat_o.pool_full    = (alloc_q >= CNT_W'(POOL_NODES));
    stat_o.tgt_nonempty = nonempty_q[tgt_ix];
    stat_o.src_nonempty = nonempty_q[src_ix];
    stat_o.same_list    = (tgt_q == src_q);
    stat_o.walk_last    = (p_q == tail_t_q) || (k_q == NODE_W'(POOL_NODES - 1));
    stat_o.out_free     = out_free;
  end

  // Allocator never passes the pool size
  a_alloc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alloc_q <= CNT_W'(POOL_NODES))
    else $error("node allocator overran the pool");

  // Results only go into a free output register
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("result loaded over a pending transfer");

  // Inserts only commit with a node left
  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit_insert |-> (alloc_q < CNT_W'(POOL_NODES) && !cmd_i.commit_splice))
    else $error("insert committed with the pool full");

  // A splice empties its source
  a_splice_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit_splice |=> !nonempty_q[$past(src_ix)])
    else $error("splice left its source nonempty");

endmodule

// File: rtl/multi_list_append_splice.sv
// ----------------------------------------------------------------------------
// multi_list_append_splice
// Several singly linked lists in one shared node pool with append, dump and
// constant-time splice.
// ----------------------------------------------------------------------------
// One request is handled at a time. For an insert, a splice, an empty dump,
// a bad index or an ignored request code, the cycle that accepts the
// transfer reads the head/tail pointer tables, and the execute state then
// updates them and loads the result (an ignored code loads none). In a
// nonempty dump, after the pointer read, the walk reads the next-link and
// value memories at one node per cycle while the output is not stalled.
// The result register lets a new request be accepted while the last
// result of the previous one still waits. Nodes are allocated in order and
// never freed; after 64 inserts, every further insert reports pool full.
// The lists_in_use register may only be written while the block is idle.
// ----------------------------------------------------------------------------
module multi_list_append_splice (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mlas_pkg::CFG_W-1:0]        cfg_lists_in_use_i,
  // request channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [mlas_pkg::REQ_W-1:0]        req_type_i,
  input  logic [mlas_pkg::IDX_W-1:0]        target_list_i,
  input  logic [mlas_pkg::IDX_W-1:0]        source_list_i,
  input  logic signed [31:0]                value_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [mlas_pkg::OUT_W-1:0] out_value_o,
  output logic                              is_last_o,
  output logic                              is_empty_o,
  output logic [1:0]                        status_o
);
  import mlas_pkg::*;

  mlas_cmd_t  cmd;
  mlas_stat_t stat;

  assign cfg_ready_o = 1'b1;

  // Sequencer
  mlas_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Tables, memories and output register
  mlas_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_lists_in_use_i (cfg_lists_in_use_i),
    .req_type_i         (req_type_i),
    .target_list_i      (target_list_i),
    .source_list_i      (source_list_i),
    .value_i            (value_i),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_value_o        (out_value_o),
    .is_last_o          (is_last_o),
    .is_empty_o         (is_empty_o),
    .status_o           (status_o)
  );

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for multi_list_append_splice: a shadow of the head/tail
// tables, the link memory and the node allocator predicts every result of
// each accepted request, and the result stream is compared field by field
// while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mlas_pkg::*;

  // One expected result transfer
  typedef struct {
    logic signed [OUT_W-1:0] value;
    logic                    last;
    logic                    empty;
    status_e                 status;
  } list_result_t;

  // Shadow of the list manager plus the queue of results still due
  class list_pool_shadow;
    logic [NODE_W-1:0]      head_ptr [NUM_LISTS];
    logic [NODE_W-1:0]      tail_ptr [NUM_LISTS];
    bit                     nonempty [NUM_LISTS];
    logic [NODE_W-1:0]      next_link[POOL_NODES];
    logic [VALUE_WIDTH-1:0] node_val [POOL_NODES];
    int unsigned            nodes_used;
    int unsigned            lists_in_use;
    int                     failures;
    list_result_t           due_results[$];

    function new();
      foreach (nonempty[i]) nonempty[i] = 1'b0;
      nodes_used   = 0;
      lists_in_use = LISTS_RESET;
      failures     = 0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void set_lists_in_use(logic [CFG_W-1:0] n);
      lists_in_use = n;
    endfunction

    function void add_due(logic signed [OUT_W-1:0] value, logic last, logic empty,
                          status_e status);
      list_result_t r;
      r.value  = value;
      r.last   = last;
      r.empty  = empty;
      r.status = status;
      due_results.push_back(r);
    endfunction

    // Predict the results of one accepted request and update the shadow
    function void apply_request(req_e req, logic [IDX_W-1:0] tgt,
                                logic [IDX_W-1:0] src, logic [31:0] val);
      int unsigned       lim;
      logic [NODE_W-1:0] node;
      logic [NODE_W-1:0] p;
      int                k;
      bit                done;
      if (req == REQ_IGNORED) return;
      lim = (lists_in_use > NUM_LISTS) ? NUM_LISTS : lists_in_use;
      if (tgt >= lim || (req == REQ_SPLICE && src >= lim)) begin
        add_due('0, 1'b1, 1'b0, STAT_BAD_INDEX);
        return;
      end
      case (req)
        REQ_INSERT: begin
          if (nodes_used >= POOL_NODES) begin
            add_due('0, 1'b1, 1'b0, STAT_POOL_FULL);
          end else begin
            node = nodes_used[NODE_W-1:0];
            node_val[node] = val[VALUE_WIDTH-1:0];
            if (nonempty[tgt]) next_link[tail_ptr[tgt]] = node;
            else head_ptr[tgt] = node;
            tail_ptr[tgt] = node;
            nonempty[tgt] = 1'b1;
            nodes_used++;
            add_due('0, 1'b1, 1'b0, STAT_OK);
          end
        end
        REQ_DUMP: begin
          if (!nonempty[tgt]) begin
            add_due('0, 1'b1, 1'b1, STAT_OK);
          end else begin
            // walk head to tail, never more than the pool size
            p    = head_ptr[tgt];
            k    = 0;
            done = 1'b0;
            while (!done) begin
              done = (p == tail_ptr[tgt]) || (k + 1 >= POOL_NODES);
              add_due(OUT_W'(signed'(node_val[p])), done, 1'b0, STAT_OK);
              k++;
              p = next_link[p];
            end
          end
        end
        default: begin
          // splice: empty source and self splice leave the lists alone
          if (src != tgt && nonempty[src]) begin
            if (nonempty[tgt]) next_link[tail_ptr[tgt]] = head_ptr[src];
            else head_ptr[tgt] = head_ptr[src];
            tail_ptr[tgt] = tail_ptr[src];
            nonempty[tgt] = 1'b1;
            nonempty[src] = 1'b0;
          end
          add_due('0, 1'b1, 1'b0, STAT_OK);
        end
      endcase
    endfunction

    // Compare one result transfer with the oldest prediction
    function void match_result(logic signed [OUT_W-1:0] value, logic last, logic empty,
                               logic [1:0] status);
      list_result_t r;
      if (due_results.size() == 0) begin
        $error("result with none expected: out_value=%0d is_last=%b is_empty=%b status=%0d",
               value, last, empty, status);
        failures++;
        return;
      end
      r = due_results.pop_front();
      if (value !== r.value) begin
        $error("out_value: expected %0d, got %0d", r.value, value);
        failures++;
      end
      if (last !== r.last) begin
        $error("is_last: expected %b, got %b", r.last, last);
        failures++;
      end
      if (empty !== r.empty) begin
        $error("is_empty: expected %b, got %b", r.empty, empty);
        failures++;
      end
      if (status !== r.status) begin
        $error("status: expected %0d, got %0d", r.status, status);
        failures++;
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_W-1:0]        cfg_lists;
  logic                    in_valid;
  logic                    in_stall;
  logic [REQ_W-1:0]        req_type;
  logic [IDX_W-1:0]        target_list;
  logic [IDX_W-1:0]        source_list;
  logic signed [31:0]      value;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [OUT_W-1:0] out_value;
  logic                    is_last;
  logic                    is_empty;
  logic [1:0]              status;

  list_pool_shadow tracker;
  bit              no_gaps;    // both sides run without idle cycles
  int              hold_len;   // one-off long receiver hold-off, in cycles

  multi_list_append_splice DUT (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_lists_in_use_i (cfg_lists),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .req_type_i         (req_type),
    .target_list_i      (target_list),
    .source_list_i      (source_list),
    .value_i            (value),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .out_value_o        (out_value),
    .is_last_o          (is_last),
    .is_empty_o         (is_empty),
    .status_o           (status)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #15ms;
    $display("testbench NOT OK");
    $finish;
  end

  // Monitor: results first, then config and request transfers of this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) tracker.match_result(out_value, is_last, is_empty, status);
      if (cfg_valid && cfg_ready) tracker.set_lists_in_use(cfg_lists);
      if (in_valid && !in_stall)
        tracker.apply_request(req_e'(req_type), target_list, source_list, value);
    end
  end

  // Result side: random stall per transfer, or one long hold-off on request
  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        n        = hold_len;
        hold_len = 0;
      end else begin
        n = no_gaps ? 0 : $urandom_range(0, 14);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid && hold_len == 0);
    end
  end

  // Offer one request after a random gap and hold it until it is taken
  task automatic send_request(req_e req, logic [IDX_W-1:0] tgt, logic [IDX_W-1:0] src,
                              logic [31:0] val);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= req;
    target_list <= tgt;
    source_list <= src;
    value       <= val;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop offering, wait for every due result, then let the block settle
  task automatic wait_for_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Register write; only called while idle
  task automatic write_lists_in_use(logic [CFG_W-1:0] n);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_lists <= n;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly in-range list indexes, some fully random
  function automatic logic [IDX_W-1:0] pick_list(int unsigned lim);
    if (lim == 0 || $urandom_range(0, 9) == 0) return IDX_W'($urandom_range(0, 15));
    return IDX_W'($urandom_range(0, lim - 1));
  endfunction

  task automatic send_random_requests(int count);
    int unsigned lim;
    int          roll;
    req_e        req;
    logic [31:0] val;
    repeat (count) begin
      lim  = (tracker.lists_in_use > NUM_LISTS) ? NUM_LISTS : tracker.lists_in_use;
      roll = $urandom_range(0, 99);
      if (roll < 5) req = REQ_IGNORED;
      else if (roll < 45) req = REQ_INSERT;
      else if (roll < 72) req = REQ_DUMP;
      else req = REQ_SPLICE;
      case ($urandom_range(0, 9))
        0:       val = 32'h7fff_ffff;
        1:       val = 32'h8000_0000;
        2:       val = '0;
        3:       val = '1;
        default: val = $urandom;
      endcase
      send_request(req, pick_list(lim), pick_list(lim), val);
    end
  endtask

  // Stimulus
  initial begin
    tracker     = new();
    no_gaps     = 1'b0;
    hold_len    = 0;
    rst_n       = 1'b0;
    cfg_valid   = 1'b0;
    cfg_lists   = '0;
    in_valid    = 1'b0;
    req_type    = REQ_INSERT;
    target_list = '0;
    source_list = '0;
    value       = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty dump, value extremes, splice corner cases
    send_request(REQ_DUMP,    4'd0,  4'd0,  32'h0);
    send_request(REQ_INSERT,  4'd0,  4'd9,  32'h7fff_ffff);
    send_request(REQ_INSERT,  4'd0,  4'd0,  32'h8000_0000);
    send_request(REQ_INSERT,  4'd1,  4'd15, 32'hffff_ffff);
    send_request(REQ_INSERT,  4'd1,  4'd0,  32'h0);
    send_request(REQ_DUMP,    4'd0,  4'd0,  32'h0);
    send_request(REQ_SPLICE,  4'd0,  4'd1,  32'h0);
    send_request(REQ_SPLICE,  4'd0,  4'd1,  32'h0);   // empty source
    send_request(REQ_SPLICE,  4'd0,  4'd0,  32'h0);   // onto itself
    send_request(REQ_SPLICE,  4'd15, 4'd0,  32'h0);   // empty target
    send_request(REQ_DUMP,    4'd15, 4'd0,  32'h0);
    send_request(REQ_DUMP,    4'd0,  4'd0,  32'h0);
    send_request(REQ_IGNORED, 4'd15, 4'd15, 32'hffff_ffff);
    send_request(REQ_INSERT,  4'd15, 4'd0,  32'h5555_5555);
    wait_for_idle();

    // One list in use: bad target, bad splice source, unchecked source
    write_lists_in_use(5'd1);
    send_request(REQ_INSERT,  4'd1,  4'd0,  32'haaaa_aaaa);
    send_request(REQ_SPLICE,  4'd0,  4'd5,  32'h0);
    send_request(REQ_DUMP,    4'd0,  4'd15, 32'h0);
    send_request(REQ_INSERT,  4'd0,  4'd15, 32'h1234_5678);
    send_request(REQ_SPLICE,  4'd15, 4'd0,  32'h0);
    wait_for_idle();

    // No lists in use: every index is out of range
    write_lists_in_use(5'd0);
    send_request(REQ_DUMP,    4'd0,  4'd0,  32'h0);
    send_request(REQ_INSERT,  4'd0,  4'd0,  32'h1);
    send_request(REQ_IGNORED, 4'd0,  4'd0,  32'h0);
    wait_for_idle();

    // Above the table size: clamps to all lists
    write_lists_in_use(5'd31);
    send_request(REQ_DUMP,    4'd15, 4'd0,  32'h0);
    wait_for_idle();

    // Random traffic, all lists
    write_lists_in_use(5'd16);
    send_random_requests(40);

    // Long receiver hold-off while requests keep coming, then a full drain
    hold_len = 90;
    no_gaps  = 1'b1;
    send_random_requests(24);
    no_gaps  = 1'b0;
    wait_for_idle();

    write_lists_in_use(5'd3);
    send_random_requests(35);
    wait_for_idle();

    write_lists_in_use(5'd1);
    send_random_requests(20);
    wait_for_idle();

    write_lists_in_use(5'd0);
    send_random_requests(10);
    wait_for_idle();

    write_lists_in_use(5'd31);
    no_gaps = 1'b1;
    send_random_requests(30);
    no_gaps = 1'b0;
    wait_for_idle();

    write_lists_in_use(CFG_W'($urandom_range(2, 15)));
    send_random_requests(35);
    wait_for_idle();

    // Fill the pool, overflow it, gather every node into list 0 and dump it
    write_lists_in_use(5'd16);
    while (tracker.nodes_used < POOL_NODES)
      send_request(REQ_INSERT, IDX_W'($urandom_range(0, 15)), 4'd0, $urandom);
    repeat (3) send_request(REQ_INSERT, IDX_W'($urandom_range(0, 15)), 4'd0, $urandom);
    for (int k = 1; k < NUM_LISTS; k++) send_request(REQ_SPLICE, 4'd0, IDX_W'(k), 32'h0);
    send_request(REQ_DUMP, 4'd0, 4'd0, 32'h0);
    send_random_requests(40);
    wait_for_idle();

    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/mlas_pkg.sv
rtl/mlas_ctrl.sv
rtl/mlas_dp.sv
rtl/multi_list_append_splice.sv
test/testbench.sv
